// ----- hdl/tlbd_pkg.sv -----
// Shared types and constants for the type-length block deframer.
package tlbd_pkg;

  // Type byte that marks the last block of a file ('L').
  localparam logic [7:0] LastType = 8'h4C;

  // Depth of the queue between the header parser and the output stage.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoPtrW + 1;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PhType  = 4'b0001,
    PhLenHi = 4'b0010,
    PhLenLo = 4'b0100,
    PhData  = 4'b1000
  } tlbd_phase_e;

  // One result as it travels from the parser to the output ports.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_data;
    logic       block_end;
    logic       file_end;
  } tlbd_res_t;

endpackage

// ----- hdl/type_length_block_deframer.sv -----
// Top level of the type-length block deframer.
//
// Splits a received byte stream into blocks of the form: type byte, 16-bit
// big-endian unsigned length, then that many payload bytes. Type 'L' (0x4C)
// marks the last block of a file. Each payload byte comes out as one result
// with is_data set; the final byte of a block also carries block_end, and
// file_end when the block was an 'L' block. A header with length zero gives
// one result with only file_end set, whatever its type. Header bytes give no
// result. After a file ends the next byte is taken as a new type byte.
// Rate: one byte per clock cycle is accepted, with no gaps, as long as
// results are popped; the parser handles each byte as it comes (phase
// update and 16-bit count decrement). A four-entry queue plus one output
// register lets up to five results wait before full rises. Each result
// passes through the queue and then the output register to the ports.
module type_length_block_deframer
  import tlbd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte_o,
  output logic       is_data_o,
  output logic       block_end_o,
  output logic       file_end_o
);

  logic      accept;
  logic      front_valid;
  tlbd_res_t front_res;
  logic      q_valid;
  logic      q_take;
  tlbd_res_t q_data;
  tlbd_res_t out_res;

  // A byte is taken only while the queue has room for whatever it produces.
  assign accept = push && !full;

  tlbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .res_valid_o (front_valid),
    .res_o       (front_res)
  );

  tlbd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (front_valid),
    .wr_data_i   (front_res),
    .rd_en_i     (q_take),
    .rd_data_o   (q_data),
    .not_empty_o (q_valid),
    .full_o      (full)
  );

  tlbd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_take_o  (q_take),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (out_res)
  );

  assign data_byte_o = out_res.data_byte;
  assign is_data_o   = out_res.is_data;
  assign block_end_o = out_res.block_end;
  assign file_end_o  = out_res.file_end;

endmodule

// ----- hdl/tlbd_front.sv -----
// Header parser: tracks block phase and payload count, classifies each byte.
module tlbd_front
  import tlbd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  output logic       res_valid_o,
  output tlbd_res_t  res_o
);

  tlbd_phase_e phase_q, phase_d;
  logic        last_blk_q, last_blk_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] remain_q, remain_d;
  logic [15:0] len_full;
  logic [15:0] remain_dec;

  assign len_full   = {len_hi_q, in_byte_i};
  assign remain_dec = (remain_q != 16'd0) ? remain_q - 16'd1 : remain_q;

  always_comb begin
    phase_d     = phase_q;
    last_blk_d  = last_blk_q;
    len_hi_d    = len_hi_q;
    remain_d    = remain_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      unique case (phase_q)
        PhType: begin
          last_blk_d = (in_byte_i == LastType);
          phase_d    = PhLenHi;
        end
        PhLenHi: begin
          len_hi_d = in_byte_i;
          phase_d  = PhLenLo;
        end
        PhLenLo: begin
          remain_d = len_full;
          if (len_full == 16'd0) begin
            // empty block ends the file right away
            phase_d        = PhType;
            res_valid_o    = 1'b1;
            res_o.file_end = 1'b1;
          end else begin
            phase_d = PhData;
          end
        end
        PhData: begin
          remain_d        = remain_dec;
          res_valid_o     = 1'b1;
          res_o.data_byte = in_byte_i;
          res_o.is_data   = 1'b1;
          if (remain_dec == 16'd0) begin
            phase_d         = PhType;
            res_o.block_end = 1'b1;
            res_o.file_end  = last_blk_q;
          end
        end
        default: begin
          phase_d = PhType;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhType;
      last_blk_q <= 1'b0;
      len_hi_q   <= 8'd0;
      remain_q   <= 16'd0;
    end else begin
      phase_q    <= phase_d;
      last_blk_q <= last_blk_d;
      len_hi_q   <= len_hi_d;
      remain_q   <= remain_d;
    end
  end

endmodule

// ----- hdl/tlbd_fifo.sv -----
// Short result queue between the parser and the output stage.
module tlbd_fifo
  import tlbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_en_i,
  input  tlbd_res_t wr_data_i,
  input  logic      rd_en_i,
  output tlbd_res_t rd_data_o,
  output logic      not_empty_o,
  output logic      full_o
);

  tlbd_res_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]   count_q;
  logic                  do_wr, do_rd;

  assign full_o      = (count_q == FifoCntW'(FifoDepth));
  assign not_empty_o = (count_q != '0);
  assign do_wr       = wr_en_i && !full_o;
  assign do_rd       = rd_en_i && not_empty_o;
  assign rd_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + FifoCntW'(1);
        2'b01:   count_q <= count_q - FifoCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- hdl/tlbd_back.sv -----
// Output stage: holds the oldest result on the ports until it is popped.
module tlbd_back
  import tlbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  tlbd_res_t q_data_i,
  output logic      q_take_o,
  input  logic      pop_i,
  output logic      empty_o,
  output tlbd_res_t res_o
);

  logic      valid_q;
  tlbd_res_t res_q;

  // refill when the slot is free or being drained this cycle
  assign q_take_o = q_valid_i && (!valid_q || pop_i);
  assign empty_o  = !valid_q;
  assign res_o    = res_q;

  always_ff @(posedge clk_i) begin
    if (q_take_o) begin
      res_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_take_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule
